/* rtl/core/hpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue package
// Sizes, codes and shared types of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int PRIO_W       = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CHILD_W      = IDX_W + 2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_FIN,
        S_RD_TOP,
        S_TOP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef enum logic {
        MODE_UP,
        MODE_DOWN
    } cmp_mode_t;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_A,
        SEL_B
    } cmp_sel_t;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        cmp_mode_t                mode;
        logic signed [PRIO_W-1:0] item_prio;
        logic signed [PRIO_W-1:0] a_prio;
        logic                     a_ok;
        logic signed [PRIO_W-1:0] b_prio;
        logic                     b_ok;
    } cmp_in_t;

endpackage

/* rtl/core/hpq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue channels
// Valid/ready interfaces for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface hpq_req_if;
    logic                                valid;
    logic                                ready;
    hpq_pkg::op_t                        operation;
    logic [hpq_pkg::PAYLOAD_BITS-1:0]    payload;
    logic signed [hpq_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, operation, payload, priority_req, input ready);
    modport sink (input valid, operation, payload, priority_req, output ready);
endinterface

interface hpq_rsp_if;
    logic                                valid;
    logic                                ready;
    hpq_pkg::status_t                    status;
    logic [hpq_pkg::PAYLOAD_BITS-1:0]    payload_out;
    logic signed [hpq_pkg::PRIO_W-1:0]   priority_out;
    logic [hpq_pkg::CNT_W-1:0]           count;

    modport source (output valid, status, payload_out, priority_out, count, input ready);
    modport sink (input valid, status, payload_out, priority_out, count, output ready);
endinterface

interface hpq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hpq_pkg::CNT_W-1:0]     capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink (input valid, capacity_limit, output ready);
endinterface

/* rtl/core/hpq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap storage RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int WIDTH   = 64,
    parameter int DEPTH_P = 64,
    parameter int AW      = $clog2(DEPTH_P)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH_P];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* rtl/core/hpq_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap compare unit
// Signed priority compare shared by the sift-up and sift-down steps.
// ----------------------------------------------------------------------------
module hpq_cmp (
    input  hpq_pkg::cmp_in_t  cmp_in,
    output hpq_pkg::cmp_sel_t sel
);
    import hpq_pkg::*;

    logic a_gt_item;
    logic b_gt_item;
    logic b_gt_a;
    logic item_gt_a;

    assign a_gt_item = $signed(cmp_in.a_prio) > $signed(cmp_in.item_prio);
    assign b_gt_item = $signed(cmp_in.b_prio) > $signed(cmp_in.item_prio);
    assign b_gt_a    = $signed(cmp_in.b_prio) > $signed(cmp_in.a_prio);
    assign item_gt_a = $signed(cmp_in.item_prio) > $signed(cmp_in.a_prio);

    always_comb
    begin
        sel = SEL_NONE;
        case (cmp_in.mode)
            MODE_UP:
            begin
                // The rising entry passes its parent only when strictly greater.
                if (cmp_in.a_ok && item_gt_a)
                begin
                    sel = SEL_A;
                end
            end
            MODE_DOWN:
            begin
                // The left child wins ties; a child must beat the best so far.
                if (cmp_in.a_ok && a_gt_item)
                begin
                    sel = SEL_A;
                    if (cmp_in.b_ok && b_gt_a)
                    begin
                        sel = SEL_B;
                    end
                end
                else if (cmp_in.b_ok && b_gt_item)
                begin
                    sel = SEL_B;
                end
            end
            default:
            begin
                sel = SEL_NONE;
            end
        endcase
    end

endmodule

/* rtl/core/binary_max_heap_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Fixed-capacity heap of payload and signed priority entries with push, pop,
// peek and clear requests, one result per request.
// ----------------------------------------------------------------------------
// The heap holds up to 64 entries in a two-read, one-write RAM and handles one
// request at a time; ready is low while a request is in progress. Clear, a
// rejected push, a push into an empty heap and a pop or peek of an empty heap
// go straight from the request to the result state. Peek and pop first read
// the root and the last entry; a pop then moves the last entry to the root,
// unless it was the only one, and sinks it. A push raises the new entry from
// the first free slot, with an extra write step when it reaches the root. Each
// heap level is a RAM read state and then a compare-and-write state of the
// shared compare unit. A finished result sits in an output register, so the
// next request is accepted while the previous result waits to be taken. The
// capacity register may be written at any time the block is idle; its write
// channel is always ready.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue (
    input  logic clk,
    input  logic rst_n,
    hpq_req_if.sink   req,
    hpq_rsp_if.source rsp,
    hpq_cfg_if.sink   cfg
);
    import hpq_pkg::*;

    // Sequencer state and working registers.
    state_t            state_reg,      state_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic [CNT_W-1:0]  capacity_reg,   capacity_next;
    logic [IDX_W-1:0]  node_reg,       node_next;
    entry_t            item_reg,       item_next;
    logic              is_pop_reg,     is_pop_next;
    status_t           res_status_reg, res_status_next;
    entry_t            res_entry_reg,  res_entry_next;

    // Output register.
    logic              rsp_valid_reg,  rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    entry_t            rsp_entry_reg,  rsp_entry_next;
    logic [CNT_W-1:0]  rsp_count_reg,  rsp_count_next;

    // RAM port controls.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic [$bits(entry_t)-1:0] rd_vec_a;
    logic [$bits(entry_t)-1:0] rd_vec_b;
    entry_t            rd_data_a;
    entry_t            rd_data_b;

    // Compare unit.
    cmp_in_t           cmp_in;
    cmp_sel_t          cmp_sel;

    // Address arithmetic for the current node.
    logic [CNT_W-1:0]   cap_eff;
    logic [IDX_W-1:0]   parent_idx;
    logic [CHILD_W-1:0] left_idx;
    logic [CHILD_W-1:0] right_idx;
    logic               left_ok;
    logic               right_ok;
    logic [CNT_W-1:0]   last_idx;

    hpq_ram #(
        .WIDTH   ($bits(entry_t)),
        .DEPTH_P (DEPTH),
        .AW      (IDX_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_vec_a),
        .rd_data_b (rd_vec_b)
    );

    assign rd_data_a = entry_t'(rd_vec_a);
    assign rd_data_b = entry_t'(rd_vec_b);

    hpq_cmp u_cmp (
        .cmp_in (cmp_in),
        .sel    (cmp_sel)
    );

    // A capacity above the storage depth is treated as the depth.
    assign cap_eff = (capacity_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;

    // Parent of node i is (i - 1) / 2; children are 2i + 1 and 2i + 2.
    assign parent_idx = (node_reg - IDX_W'(1)) >> 1;
    assign left_idx   = {1'b0, node_reg, 1'b1};
    assign right_idx  = left_idx + CHILD_W'(1);
    assign left_ok    = left_idx < CHILD_W'(count_reg);
    assign right_ok   = right_idx < CHILD_W'(count_reg);
    assign last_idx   = count_reg - CNT_W'(1);

    // The capacity register is written whenever a write request arrives.
    assign cfg.ready     = 1'b1;
    assign capacity_next = (cfg.valid && cfg.ready) ? cfg.capacity_limit : capacity_reg;

    // Requests are taken only while the sequencer is idle.
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        node_next       = node_reg;
        item_next       = item_reg;
        is_pop_next     = is_pop_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;

        wr_en     = 1'b0;
        wr_addr   = node_reg;
        wr_data   = item_reg;
        rd_addr_a = '0;
        rd_addr_b = '0;

        cmp_in.mode      = MODE_DOWN;
        cmp_in.item_prio = item_reg.prio;
        cmp_in.a_prio    = rd_data_a.prio;
        cmp_in.a_ok      = 1'b0;
        cmp_in.b_prio    = rd_data_b.prio;
        cmp_in.b_ok      = 1'b0;

        // The result leaves the output register when taken.
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_count_next  = rsp_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = ST_OK;
                    res_entry_next  = '0;
                    state_next      = S_DONE;
                    case (req.operation)
                        OP_PUSH:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // The new entry starts in the first free slot.
                                item_next.payload = req.payload;
                                item_next.prio    = req.priority_req;
                                node_next         = count_reg[IDX_W-1:0];
                                count_next        = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data.payload = req.payload;
                                    wr_data.prio    = req.priority_req;
                                end
                                else
                                begin
                                    state_next = S_UP_RD;
                                end
                            end
                        end
                        OP_POP,
                        OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                is_pop_next = (req.operation == OP_POP);
                                state_next  = S_RD_TOP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                rd_addr_a  = parent_idx;
                state_next = S_UP_CMP;
            end

            S_UP_CMP:
            begin
                // Move the parent down into the hole, or drop the entry here.
                cmp_in.mode = MODE_UP;
                cmp_in.a_ok = 1'b1;
                wr_en       = 1'b1;
                if (cmp_sel == SEL_A)
                begin
                    wr_data   = rd_data_a;
                    node_next = parent_idx;
                    state_next = (parent_idx == '0) ? S_UP_FIN : S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_UP_FIN:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            S_RD_TOP:
            begin
                rd_addr_a  = '0;
                rd_addr_b  = last_idx[IDX_W-1:0];
                state_next = S_TOP;
            end

            S_TOP:
            begin
                res_entry_next = rd_data_a;
                state_next     = S_DONE;
                if (is_pop_reg)
                begin
                    // The last entry fills the root and sinks from there.
                    count_next = last_idx;
                    item_next  = rd_data_b;
                    node_next  = '0;
                    if (last_idx != '0)
                    begin
                        state_next = S_DN_RD;
                    end
                end
            end

            S_DN_RD:
            begin
                if (left_ok)
                begin
                    rd_addr_a  = left_idx[IDX_W-1:0];
                    rd_addr_b  = right_idx[IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DN_CMP:
            begin
                cmp_in.mode = MODE_DOWN;
                cmp_in.a_ok = left_ok;
                cmp_in.b_ok = right_ok;
                wr_en       = 1'b1;
                case (cmp_sel)
                    SEL_A:
                    begin
                        wr_data    = rd_data_a;
                        node_next  = left_idx[IDX_W-1:0];
                        state_next = S_DN_RD;
                    end
                    SEL_B:
                    begin
                        wr_data    = rd_data_b;
                        node_next  = right_idx[IDX_W-1:0];
                        state_next = S_DN_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_entry_next  = res_entry_reg;
                    rsp_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            capacity_reg  <= CNT_W'(DEPTH);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            capacity_reg  <= capacity_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        item_reg       <= item_next;
        is_pop_reg     <= is_pop_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        rsp_status_reg <= rsp_status_next;
        rsp_entry_reg  <= rsp_entry_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.payload_out  = rsp_entry_reg.payload;
    assign rsp.priority_out = rsp_entry_reg.prio;
    assign rsp.count        = rsp_count_reg;

endmodule

/* rtl/core/hpq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap priority queue checker
// Port-level checks of the heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module hpq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input hpq_pkg::status_t                  rsp_status,
    input logic [hpq_pkg::PAYLOAD_BITS-1:0]  rsp_payload,
    input logic signed [hpq_pkg::PRIO_W-1:0] rsp_priority,
    input logic [hpq_pkg::CNT_W-1:0]         rsp_count
);
    import hpq_pkg::*;

    // A waiting result keeps its payload and count until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload) && $stable(rsp_count))
        else $error("result changed while stalled");

    // Failed requests carry no entry.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_payload == '0 && rsp_priority == '0)
        else $error("failed request returned an entry");

    // An empty report means the heap holds nothing.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
        else $error("empty report with nonzero count");

    // The count never exceeds the storage depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= CNT_W'(DEPTH))
        else $error("count beyond heap depth");

    // Every accepted request keeps the block busy in the cycle after it.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted in back-to-back cycles");

endmodule

bind binary_max_heap_priority_queue hpq_checker u_hpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_payload  (rsp.payload_out),
    .rsp_priority (rsp.priority_out),
    .rsp_count    (rsp.count)
);

/* tb/sv/tb_binary_max_heap_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap priority queue testbench
// Sends push, pop, peek and clear requests through the valid/ready channels
// and keeps a shadow heap that predicts every result. Each result is checked
// field by field against the oldest prediction. The capacity register is
// rewritten between phases while the queue is idle.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_priority_queue;
    import hpq_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PERCENT  = 9;
    localparam int SETTLE_CYCLES = 20;
    // A correct run takes well under a millisecond; this is several times that.
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // One predicted result, laid out like the result channel.
    typedef struct packed {
        status_t                  st;
        logic [PAYLOAD_BITS-1:0]  pay;
        logic signed [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]         cnt;
    } heap_result_t;

    // Shadow copy of the heap. It is updated when a request is accepted and
    // queues the result that request must produce.
    class heap_shadow;
        logic [PAYLOAD_BITS-1:0]  pay_slot [DEPTH];
        logic signed [PRIO_W-1:0] prio_slot [DEPTH];
        int unsigned              held;
        int unsigned              limit;
        int unsigned              errors;
        int unsigned              seen;
        heap_result_t             owed [$];

        function new();
            held   = 0;
            limit  = DEPTH;
            errors = 0;
            seen   = 0;
        endfunction

        function void set_limit(logic [CNT_W-1:0] value);
            limit = value;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [PAYLOAD_BITS-1:0]  p;
            logic signed [PRIO_W-1:0] q;
            p = pay_slot[a];
            q = prio_slot[a];
            pay_slot[a]  = pay_slot[b];
            prio_slot[a] = prio_slot[b];
            pay_slot[b]  = p;
            prio_slot[b] = q;
        endfunction

        function void apply_request(op_t op, logic [PAYLOAD_BITS-1:0] pay,
                                    logic signed [PRIO_W-1:0] prio);
            heap_result_t want;
            int unsigned  room;
            int unsigned  node;
            int unsigned  up;
            int unsigned  left;
            int unsigned  best;
            room      = (limit > DEPTH) ? DEPTH : limit;
            want.st   = ST_OK;
            want.pay  = '0;
            want.prio = '0;
            case (op)
                OP_PUSH:
                begin
                    if (held >= room)
                    begin
                        want.st = ST_FULL;
                    end
                    else
                    begin
                        pay_slot[held]  = pay;
                        prio_slot[held] = prio;
                        node = held;
                        // Rise only past parents of strictly lower priority.
                        while (node > 0)
                        begin
                            up = (node - 1) / 2;
                            if (prio_slot[node] <= prio_slot[up])
                                break;
                            swap_slots(node, up);
                            node = up;
                        end
                        held++;
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (held == 0)
                    begin
                        want.st = ST_EMPTY;
                    end
                    else
                    begin
                        want.pay  = pay_slot[0];
                        want.prio = prio_slot[0];
                        if (op == OP_POP)
                        begin
                            held--;
                            if (held > 0)
                            begin
                                pay_slot[0]  = pay_slot[held];
                                prio_slot[0] = prio_slot[held];
                                node = 0;
                                // A child must be strictly greater; the left
                                // child is tried first so it wins a tie.
                                forever
                                begin
                                    left = 2 * node + 1;
                                    best = node;
                                    if (left < held && prio_slot[left] > prio_slot[best])
                                        best = left;
                                    if (left + 1 < held
                                        && prio_slot[left + 1] > prio_slot[best])
                                        best = left + 1;
                                    if (best == node)
                                        break;
                                    swap_slots(node, best);
                                    node = best;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    held = 0;
                end
            endcase
            want.cnt = CNT_W'(held);
            owed.push_back(want);
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t ns: result %0d, %s: got %0h, expected %0h",
                     $time, seen, what, got, want);
        endtask

        task check_result(status_t st, logic [PAYLOAD_BITS-1:0] pay,
                          logic signed [PRIO_W-1:0] prio, logic [CNT_W-1:0] cnt);
            heap_result_t want;
            seen++;
            if (owed.size() == 0)
            begin
                flag_mismatch("result with no request outstanding", cnt, 0);
                return;
            end
            want = owed.pop_front();
            if (st !== want.st)
                flag_mismatch("status", st, want.st);
            if (pay !== want.pay)
                flag_mismatch("payload_out", pay, want.pay);
            if (prio !== want.prio)
                flag_mismatch("priority_out", prio, want.prio);
            if (cnt !== want.cnt)
                flag_mismatch("count", cnt, want.cnt);
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    // While set, neither the sender nor the result side idles.
    bit         steady = 1'b0;
    heap_shadow board = new();

    hpq_req_if req_ch ();
    hpq_rsp_if rsp_ch ();
    hpq_cfg_if cfg_ch ();

    binary_max_heap_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Priorities: a narrow band around zero to force ties, the extremes of the
    // signed range, and fully random values.
    function automatic logic signed [PRIO_W-1:0] any_priority();
        int band;
        case ($urandom_range(3))
            0:
            begin
                band = $urandom_range(6);
                return band - 3;
            end
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] any_payload();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge. Returns at the falling edge after the request
    // was taken, with valid still high so that a following request can go out
    // back to back; whoever stops sending lowers valid.
    task automatic send_request(input op_t op, input logic [PAYLOAD_BITS-1:0] pay,
                                input logic signed [PRIO_W-1:0] prio);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.operation    = op;
        req_ch.payload      = pay;
        req_ch.priority_req = prio;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.apply_request(op, pay, prio);
        @(negedge clk);
    endtask

    // Holds the sender off until every outstanding request has its result.
    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (board.owed.size() != 0)
            @(negedge clk);
    endtask

    // The capacity register is only written with the queue idle.
    task automatic write_capacity(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_ch.valid          = 1'b1;
        cfg_ch.capacity_limit = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.set_limit(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One random phase under one capacity. The mix leans toward pushes until
    // the heap is full and toward pops until it is empty, so that both the
    // full and the empty cases and deep sifts are reached over and over.
    task automatic run_phase(input logic [CNT_W-1:0] cap, input int unsigned items);
        int unsigned room;
        int unsigned roll;
        int unsigned push_share;
        int unsigned n;
        bit          filling;
        op_t         op;
        write_capacity(cap);
        room    = (cap > DEPTH) ? DEPTH : cap;
        filling = 1'b1;
        for (n = 0; n < items; n++)
        begin
            if (board.held >= room)
                filling = 1'b0;
            else if (board.held == 0)
                filling = 1'b1;
            roll       = $urandom_range(99);
            push_share = filling ? 72 : 26;
            if (roll < 2)
                op = OP_CLEAR;
            else if (roll < 10)
                op = OP_PEEK;
            else if (roll < 10 + push_share)
                op = OP_PUSH;
            else
                op = OP_POP;
            // Now and then the sender waits for the queue to run dry.
            if ($urandom_range(199) == 0)
                drain_results();
            send_request(op, any_payload(), any_priority());
        end
    endtask

    // Result side: ready is chosen at every falling edge, and results are
    // taken at the rising edge where valid and ready are both high.
    initial
    begin : result_side
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.status, rsp_ch.payload_out,
                               rsp_ch.priority_out, rsp_ch.count);
    end

    initial
    begin : stimulus
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_PUSH;
        req_ch.payload       = '0;
        req_ch.priority_req  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.capacity_limit = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the reset capacity of a full heap.
        // Pop and peek of an empty heap must report empty with zero fields.
        send_request(OP_POP, any_payload(), any_priority());
        send_request(OP_PEEK, any_payload(), any_priority());
        // Extremes of payload and priority.
        send_request(OP_PUSH, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0000, 32'sh8000_0000);
        send_request(OP_PUSH, 32'hA5A5_A5A5, 32'sh0000_0000);
        send_request(OP_PUSH, 32'h5A5A_5A5A, -1);
        // Equal priorities: a new entry stops below an equal parent, and on
        // the way down the left child wins a tie.
        send_request(OP_PUSH, 32'h0000_0001, 5);
        send_request(OP_PUSH, 32'h0000_0002, 5);
        send_request(OP_PUSH, 32'h0000_0003, 5);
        send_request(OP_PEEK, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());

        // Capacity lowered below the count: entries stay, pushes are refused,
        // pops and peeks still work.
        write_capacity(2);
        send_request(OP_PUSH, any_payload(), any_priority());
        send_request(OP_PEEK, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());
        send_request(OP_PUSH, any_payload(), any_priority());
        send_request(OP_CLEAR, any_payload(), any_priority());
        send_request(OP_PUSH, any_payload(), any_priority());
        send_request(OP_PUSH, any_payload(), any_priority());
        send_request(OP_PUSH, any_payload(), any_priority());

        // Capacity zero refuses every push.
        write_capacity(0);
        send_request(OP_PUSH, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());
        send_request(OP_POP, any_payload(), any_priority());

        // Random phases. A capacity above the heap depth acts as the depth.
        run_phase(127, 200);
        run_phase(1, 60);
        // A long stretch with no idling on either side.
        steady = 1'b1;
        run_phase(64, 150);
        steady = 1'b0;
        run_phase(0, 30);
        run_phase(9, 80);
        run_phase(64, 150);
        run_phase(2, 50);
        run_phase(40, 80);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb_binary_max_heap_priority_queue: clean");
        else
            $display("tb_binary_max_heap_priority_queue: errors");
        $finish;
    end

    // Ends a run that hangs, such as a result that never arrives.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_binary_max_heap_priority_queue: errors");
        $finish;
    end

endmodule
